@@ rtl/hsbc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsbc_pkg
// Shared modes, per-item control bundle and code layout helpers for the
// hamming byte stream codec.
// ----------------------------------------------------------------------------
package hsbc_pkg;

    typedef logic [1:0] hsbc_mode_t;

    localparam hsbc_mode_t MODE_ENCODE      = 2'd0;
    localparam hsbc_mode_t MODE_DECODE      = 2'd1;
    localparam hsbc_mode_t MODE_CORRECT     = 2'd2;
    localparam hsbc_mode_t MODE_CORRECT_ALT = 2'd3;

    // per-item control from the top level to the codec cores
    typedef struct packed {
        logic clear;
        logic load;
        logic last;
        logic correct;
    } hsbc_ctrl_t;

    // 0-based position p carries data unless p+1 is a power of two
    function automatic bit is_data_pos(input int p);
        int q;
        q = p + 1;
        return (q & (q - 1)) != 0;
    endfunction

    // order of a data position among the data positions of a block
    function automatic int data_index(input int p);
        int idx;
        idx = 0;
        if (is_data_pos(p)) begin
            idx = p - $clog2(p + 2);
        end
        return idx;
    endfunction

endpackage

@@ rtl/hamming_sec_byte_stream_codec_top.sv @@
// ----------------------------------------------------------------------------
// hamming_sec_byte_stream_codec_top
// Hamming single error correcting codec on a byte stream: encodes plain bytes
// into 2^BLOCK_LOG2 bit blocks, or decodes blocks with optional repair.
//
//   channel   ports                                 transfer when
//   input     s_valid s_ready s_data_byte s_last_byte   s_valid & s_ready
//   result    m_valid m_ready m_out_byte m_run_last     m_valid & m_ready
//   config    cfg_wr_en cfg_wr_data                 cfg_wr_en
//
// An input byte waits in the input register and is processed in the cycle the
// result register is empty or hands over its last byte; the result register
// then offers one byte per cycle while m_ready is high.
// In correcting mode each dropped zero byte ahead of a sent byte is stepped
// over without a transfer; dropped bytes after the last sent one are not
// waited for. An item with no results leaves the result register empty.
// Synchronous reset clears mode (encode), block state and both registers.
// A stall on the result side fills the input register, then drops s_ready.
// ----------------------------------------------------------------------------
module hamming_sec_byte_stream_codec_top
    import hsbc_pkg::*;
#(
    parameter int BLOCK_LOG2 = 5
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    localparam int B  = 1 << BLOCK_LOG2;
    localparam int OB = B / 4;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_last_reg, in_last_next;
    hsbc_mode_t mode_reg, mode_next;

    logic       s_fire, proc, buf_free;
    logic       enc_mode, dec_mode, correct;
    hsbc_ctrl_t enc_ctrl, dec_ctrl;

    logic [8*OB-1:0] enc_data, dec_data, load_data;
    logic [OB-1:0]   enc_keep, dec_keep, load_keep;

    always_comb begin
        enc_mode = mode_reg == MODE_ENCODE;
        dec_mode = mode_reg inside {MODE_DECODE, MODE_CORRECT, MODE_CORRECT_ALT};
        correct  = mode_reg inside {MODE_CORRECT, MODE_CORRECT_ALT};

        proc    = in_valid_reg && buf_free;
        s_ready = !in_valid_reg || proc;
        s_fire  = s_valid && s_ready;

        in_valid_next = s_fire ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
        in_byte_next  = s_fire ? s_data_byte : in_byte_reg;
        in_last_next  = s_fire ? s_last_byte : in_last_reg;
        mode_next     = cfg_wr_en ? cfg_wr_data : mode_reg;

        enc_ctrl = '{clear: cfg_wr_en, load: proc && enc_mode,
                     last: in_last_reg, correct: 1'b0};
        dec_ctrl = '{clear: cfg_wr_en, load: proc && dec_mode,
                     last: in_last_reg, correct: correct};

        load_data = enc_mode ? enc_data : dec_data;
        load_keep = enc_mode ? enc_keep : dec_keep;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_ENCODE;
        end else begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
    end

    hsbc_encoder #(
        .BLOCK_LOG2 (BLOCK_LOG2)
    ) u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (enc_ctrl),
        .data_byte (in_byte_reg),
        .blk_data  (enc_data),
        .blk_keep  (enc_keep)
    );

    hsbc_decoder #(
        .BLOCK_LOG2 (BLOCK_LOG2)
    ) u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (dec_ctrl),
        .data_byte (in_byte_reg),
        .blk_data  (dec_data),
        .blk_keep  (dec_keep)
    );

    hsbc_out_buf #(
        .NUM_BYTES (OB)
    ) u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (proc),
        .load_data  (load_data),
        .load_keep  (load_keep),
        .free       (buf_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

endmodule

@@ rtl/hsbc_syndrome.sv @@
// ----------------------------------------------------------------------------
// hsbc_syndrome
// Parity check of one block: xor of the 1-based numbers of all set positions.
// ----------------------------------------------------------------------------
module hsbc_syndrome
    import hsbc_pkg::*;
#(
    parameter int BLOCK_LOG2 = 5
) (
    input  logic [(1 << BLOCK_LOG2)-1:0] code_word,
    output logic [BLOCK_LOG2-1:0]        syndrome
);

    localparam int B = 1 << BLOCK_LOG2;

    // positions covered by check bit a
    function automatic logic [B-1:0] cover_mask(input int a);
        logic [B-1:0] m;
        m = '0;
        for (int p = 0; p < B; p++) begin
            m[B-1-p] = 1'(((p + 1) >> a) & 1);
        end
        return m;
    endfunction

    always_comb begin
        for (int a = 0; a < BLOCK_LOG2; a++) begin
            syndrome[a] = ^(code_word & cover_mask(a));
        end
    end

endmodule

@@ rtl/hsbc_encoder.sv @@
// ----------------------------------------------------------------------------
// hsbc_encoder
// Gathers data bits of the open block and builds up to two code blocks per
// input byte (one full block plus a padded final block, or two full blocks).
// ----------------------------------------------------------------------------
module hsbc_encoder
    import hsbc_pkg::*;
#(
    parameter int BLOCK_LOG2 = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hsbc_ctrl_t                      ctrl,
    input  logic [7:0]                      data_byte,
    output logic [2*(1 << BLOCK_LOG2)-1:0]  blk_data,
    output logic [(1 << BLOCK_LOG2)/4-1:0]  blk_keep
);

    localparam int B    = 1 << BLOCK_LOG2;
    localparam int D    = B - BLOCK_LOG2 - 1;
    localparam int BB   = B / 8;
    localparam int VW   = D + 8;
    localparam int CNTW = $clog2(VW);
    localparam int DCW  = $clog2(D);

    logic [D-1:0]       dv_reg, dv_next;
    logic [DCW-1:0]     dcount_reg, dcount_next;

    logic [VW-1:0]      v0, v1, v2;
    logic [CNTW-1:0]    cnt0, cnt1, cnt2;
    logic               full1, full2, slot0_on, slot1_on;
    logic [B-1:0]       cw0_data, cw1_data, cw0, cw1;
    logic [BLOCK_LOG2-1:0] syn0, syn1;

    function automatic logic [B-1:0] place_data(input logic [D-1:0] dv);
        logic [B-1:0] w;
        w = '0;
        for (int p = 0; p < B; p++) begin
            if (is_data_pos(p)) begin
                w[B-1-p] = dv[D-1-data_index(p)];
            end
        end
        return w;
    endfunction

    function automatic logic [B-1:0] add_parity(input logic [B-1:0] w,
                                                input logic [BLOCK_LOG2-1:0] syn);
        logic [B-1:0] r;
        r = w;
        for (int a = 0; a < BLOCK_LOG2; a++) begin
            r[B-(1 << a)] = syn[a];
        end
        return r;
    endfunction

    // append the byte behind the bits already held, then peel off full blocks
    always_comb begin
        v0    = {dv_reg, 8'h00} | ({data_byte, {D{1'b0}}} >> dcount_reg);
        cnt0  = CNTW'(dcount_reg) + CNTW'(8);
        full1 = cnt0 >= CNTW'(D);
        v1    = full1 ? (v0 << D) : v0;
        cnt1  = full1 ? (cnt0 - CNTW'(D)) : cnt0;
        full2 = full1 && (cnt1 >= CNTW'(D));
        v2    = full2 ? (v1 << D) : v1;
        cnt2  = full2 ? (cnt1 - CNTW'(D)) : cnt1;

        slot0_on = full1 || ctrl.last;
        slot1_on = full1 && (full2 || (ctrl.last && (cnt1 != '0)));

        cw0_data = place_data(v0[VW-1 -: D]);
        cw1_data = place_data(v1[VW-1 -: D]);
    end

    hsbc_syndrome #(
        .BLOCK_LOG2 (BLOCK_LOG2)
    ) u_syn0 (
        .code_word (cw0_data),
        .syndrome  (syn0)
    );

    hsbc_syndrome #(
        .BLOCK_LOG2 (BLOCK_LOG2)
    ) u_syn1 (
        .code_word (cw1_data),
        .syndrome  (syn1)
    );

    always_comb begin
        cw0      = add_parity(cw0_data, syn0);
        cw1      = add_parity(cw1_data, syn1);
        blk_data = {cw0, cw1};
        blk_keep = {{BB{slot0_on}}, {BB{slot1_on}}};
    end

    always_comb begin
        dv_next     = dv_reg;
        dcount_next = dcount_reg;
        if (ctrl.clear) begin
            dv_next     = '0;
            dcount_next = '0;
        end else if (ctrl.load) begin
            if (ctrl.last) begin
                dv_next     = '0;
                dcount_next = '0;
            end else begin
                dv_next     = v2[VW-1 -: D];
                dcount_next = DCW'(cnt2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg     <= '0;
            dcount_reg <= '0;
        end else begin
            dv_reg     <= dv_next;
            dcount_reg <= dcount_next;
        end
    end

    a_dv_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_reg << dcount_reg) == '0)
        else $error("encoder holds stray bits past the fill point");

    a_dcount_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(dcount_reg) < D)
        else $error("encoder fill count reached a full block");

endmodule

@@ rtl/hsbc_decoder.sv @@
// ----------------------------------------------------------------------------
// hsbc_decoder
// Collects coded bytes into a block, checks and optionally repairs it, and
// packs its data bits behind the leftover bits into output bytes.
// ----------------------------------------------------------------------------
module hsbc_decoder
    import hsbc_pkg::*;
#(
    parameter int BLOCK_LOG2 = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hsbc_ctrl_t                      ctrl,
    input  logic [7:0]                      data_byte,
    output logic [2*(1 << BLOCK_LOG2)-1:0]  blk_data,
    output logic [(1 << BLOCK_LOG2)/4-1:0]  blk_keep
);

    localparam int B    = 1 << BLOCK_LOG2;
    localparam int D    = B - BLOCK_LOG2 - 1;
    localparam int BB   = B / 8;
    localparam int OB   = B / 4;
    localparam int DW   = D + 7;
    localparam int NDEC = DW / 8;
    localparam int TW   = $clog2(DW + 1);
    localparam int NBW  = TW - 3;
    localparam int BIW  = (BLOCK_LOG2 > 3) ? BLOCK_LOG2 - 3 : 1;

    logic [B-1:0]     blk_reg, blk_next;
    logic [BIW-1:0]   bcnt_reg, bcnt_next;
    logic [6:0]       acc_reg, acc_next;
    logic [2:0]       afill_reg, afill_next;

    logic [B-1:0]          blk_new, flip_vec, fixed;
    logic [BLOCK_LOG2-1:0] syn;
    logic                  full, go;
    logic [D-1:0]          dd;
    logic [DW-1:0]         xv, sv;
    logic [TW-1:0]         total;
    logic [NBW-1:0]        nbytes;
    logic [2:0]            rem;
    logic [6:0]            new_acc;

    function automatic logic [D-1:0] extract_data(input logic [B-1:0] w);
        logic [D-1:0] r;
        r = '0;
        for (int p = 0; p < B; p++) begin
            if (is_data_pos(p)) begin
                r[D-1-data_index(p)] = w[B-1-p];
            end
        end
        return r;
    endfunction

    always_comb begin
        blk_new = blk_reg | ({data_byte, {(B-8){1'b0}}} >> {bcnt_reg, 3'b000});
        full    = bcnt_reg == BIW'(BB - 1);
        go      = full || ctrl.last;
    end

    hsbc_syndrome #(
        .BLOCK_LOG2 (BLOCK_LOG2)
    ) u_syn (
        .code_word (blk_new),
        .syndrome  (syn)
    );

    always_comb begin
        // a nonzero syndrome names the 1-based position to flip
        flip_vec = (ctrl.correct && (syn != '0))
                 ? ({1'b1, {(B-1){1'b0}}} >> (syn - BLOCK_LOG2'(1))) : '0;
        fixed    = blk_new ^ flip_vec;
        dd       = extract_data(fixed);

        // leftover bits sit in the low end of acc_reg, right above the new data
        xv      = {acc_reg, dd};
        total   = TW'(afill_reg) + TW'(D);
        nbytes  = total[TW-1:3];
        rem     = total[2:0];
        sv      = xv << (3'd7 - afill_reg);
        new_acc = xv[6:0] & ~(7'h7f << rem);

        blk_data = {sv[DW-1 -: 8*NDEC], {(8*(OB-NDEC)){1'b0}}};
        blk_keep = '0;
        for (int i = 0; i < NDEC; i++) begin
            blk_keep[OB-1-i] = go && (NBW'(i) < nbytes)
                             && !(ctrl.correct && (sv[DW-1-8*i -: 8] == 8'h00));
        end
    end

    always_comb begin
        blk_next   = blk_reg;
        bcnt_next  = bcnt_reg;
        acc_next   = acc_reg;
        afill_next = afill_reg;
        if (ctrl.clear) begin
            blk_next   = '0;
            bcnt_next  = '0;
            acc_next   = '0;
            afill_next = '0;
        end else if (ctrl.load) begin
            if (ctrl.last) begin
                blk_next   = '0;
                bcnt_next  = '0;
                acc_next   = '0;
                afill_next = '0;
            end else if (full) begin
                blk_next   = '0;
                bcnt_next  = '0;
                acc_next   = new_acc;
                afill_next = rem;
            end else begin
                blk_next  = blk_new;
                bcnt_next = bcnt_reg + BIW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg   <= '0;
            bcnt_reg  <= '0;
            acc_reg   <= '0;
            afill_reg <= '0;
        end else begin
            blk_reg   <= blk_next;
            bcnt_reg  <= bcnt_next;
            acc_reg   <= acc_next;
            afill_reg <= afill_next;
        end
    end

    a_blk_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (blk_reg << {bcnt_reg, 3'b000}) == '0)
        else $error("decoder block holds bits past the fill point");

    a_acc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg >> afill_reg) == '0)
        else $error("decoder leftover bits exceed their count");

endmodule

@@ rtl/hsbc_out_buf.sv @@
// ----------------------------------------------------------------------------
// hsbc_out_buf
// Result register for one item: a byte shift line with a keep mask, one byte
// offered per cycle while m_ready is high; skipped bytes need no transfer.
// ----------------------------------------------------------------------------
module hsbc_out_buf
    import hsbc_pkg::*;
#(
    parameter int NUM_BYTES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [8*NUM_BYTES-1:0] load_data,
    input  logic [NUM_BYTES-1:0]   load_keep,
    output logic                   free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_run_last
);

    localparam int DW = 8 * NUM_BYTES;

    logic [DW-1:0]        data_reg, data_next;
    logic [NUM_BYTES-1:0] keep_reg, keep_next;
    logic                 rest_empty, advance;

    always_comb begin
        rest_empty = keep_reg[NUM_BYTES-2:0] == '0;
        m_valid    = keep_reg[NUM_BYTES-1];
        m_out_byte = data_reg[DW-1 -: 8];
        m_run_last = rest_empty;
        // empty, or the last kept byte leaves in this cycle
        free       = (keep_reg == '0) || (rest_empty && m_ready);
        advance    = (keep_reg != '0) && (!keep_reg[NUM_BYTES-1] || m_ready);

        data_next = data_reg;
        keep_next = keep_reg;
        if (load) begin
            data_next = load_data;
            keep_next = load_keep;
        end else if (advance) begin
            data_next = data_reg << 8;
            keep_next = keep_reg << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= '0;
        end else begin
            keep_reg <= keep_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("results loaded over undelivered results");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_run_last && !load) |=> !m_valid)
        else $error("result offered after the last one of its item");

endmodule
